/* rtl/core/gwp_pkg.sv */
// ----------------------------------------------------------------------------
// gwp_pkg: shared types and constants for the G-code word parser
// Number format, saturation limits and the control word passed to the
// digit accumulator.
// ----------------------------------------------------------------------------
package gwp_pkg;

  // Decimal digits kept after the point; values are scaled by 10^FRACTION_DIGITS.
  localparam int FRACTION_DIGITS = 3;
  // Width of a word value including sign.
  localparam int VALUE_BITS      = 32;

  // Width of the result position fields and of the power field.
  localparam int OUT_W   = 32;
  localparam int POWER_W = 23;
  localparam logic [63:0] POWER_MAX = 64'((64'd1 << (POWER_W - 1)) - 64'd1);

  // Power of ten lookup, exponent 0..6.
  function automatic logic [63:0] pow10(input logic [2:0] e);
    logic [63:0] r;
    case (e)
      3'd0:    r = 64'd1;
      3'd1:    r = 64'd10;
      3'd2:    r = 64'd100;
      3'd3:    r = 64'd1000;
      3'd4:    r = 64'd10000;
      3'd5:    r = 64'd100000;
      3'd6:    r = 64'd1000000;
      default: r = 64'd1;
    endcase
    return r;
  endfunction

  localparam logic [63:0] SCALE = pow10(3'(FRACTION_DIGITS));

  // Magnitude width and its saturation value.
  localparam int MAG_W = VALUE_BITS - 1;
  localparam logic [MAG_W-1:0] MAG_MAX = '1;
  localparam logic [63:0] MAXV = 64'(MAG_MAX);

  // Integer part of the magnitude, tracked alongside for the power field.
  localparam logic [63:0] INT_SAT = MAXV / SCALE;
  localparam int INT_W = (INT_SAT == 64'd0) ? 1 : $clog2(INT_SAT + 64'd1);

  // Headroom for acc*10 + d*SCALE.
  localparam int WIDE_W = MAG_W + 28;

  // Fraction digit counter width.
  localparam int FC_W = (FRACTION_DIGITS < 1) ? 1 : $clog2(FRACTION_DIGITS + 1);

  // Per-byte control for the accumulator.
  typedef struct packed {
    logic       clear;
    logic       digit;
    logic       minus;
    logic       point;
    logic [3:0] dval;
  } acc_ctl_t;

endpackage

/* rtl/core/gwp_accum.sv */
// ----------------------------------------------------------------------------
// gwp_accum: decimal word accumulator
// Builds one word's fixed-point magnitude from digits, tracks sign and
// point, saturates, and keeps the integer part for the power field.
// ----------------------------------------------------------------------------
module gwp_accum (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  gwp_pkg::acc_ctl_t                     ctl,
  output logic signed [gwp_pkg::VALUE_BITS-1:0] value,
  output logic signed [gwp_pkg::POWER_W-1:0]    power
);

  logic [gwp_pkg::MAG_W-1:0]  acc_r, acc_nxt;
  logic [gwp_pkg::INT_W-1:0]  int_r, int_nxt;
  logic [gwp_pkg::FC_W-1:0]   fc_r, fc_nxt;
  logic                       point_r, point_nxt;
  logic                       minus_r, minus_nxt;

  logic [gwp_pkg::WIDE_W-1:0] wide_acc;
  logic [gwp_pkg::WIDE_W-1:0] int_prod;
  logic [gwp_pkg::WIDE_W-1:0] frac_sum;
  logic [gwp_pkg::INT_W+3:0]  int10;
  logic [gwp_pkg::FC_W-1:0]   fc_inc;
  logic                       frac_ok;
  logic [gwp_pkg::VALUE_BITS-1:0] mag;
  logic [63:0]                int_cap;

  always_comb begin
    wide_acc = gwp_pkg::WIDE_W'(acc_r);
    fc_inc   = fc_r + gwp_pkg::FC_W'(1);
    frac_ok  = fc_r < gwp_pkg::FC_W'(gwp_pkg::FRACTION_DIGITS);
    int_prod = (wide_acc << 3) + (wide_acc << 1)
             + gwp_pkg::WIDE_W'(ctl.dval) * gwp_pkg::WIDE_W'(gwp_pkg::SCALE);
    frac_sum = wide_acc + gwp_pkg::WIDE_W'(ctl.dval)
             * gwp_pkg::WIDE_W'(gwp_pkg::pow10(3'(gwp_pkg::FRACTION_DIGITS) - 3'(fc_inc)));
    int10    = (gwp_pkg::INT_W+4)'(int_r) * (gwp_pkg::INT_W+4)'(10)
             + (gwp_pkg::INT_W+4)'(ctl.dval);

    acc_nxt   = acc_r;
    int_nxt   = int_r;
    fc_nxt    = fc_r;
    point_nxt = point_r || ctl.point;
    minus_nxt = minus_r || ctl.minus;

    if (ctl.clear) begin
      acc_nxt   = '0;
      int_nxt   = '0;
      fc_nxt    = '0;
      point_nxt = 1'b0;
      minus_nxt = 1'b0;
    end else if (ctl.digit) begin
      if (!point_r) begin
        if (int_prod > gwp_pkg::WIDE_W'(gwp_pkg::MAXV)) begin
          acc_nxt = gwp_pkg::MAG_MAX;
          int_nxt = gwp_pkg::INT_W'(gwp_pkg::INT_SAT);
        end else begin
          acc_nxt = gwp_pkg::MAG_W'(int_prod);
          int_nxt = gwp_pkg::INT_W'(int10);
        end
      end else if (frac_ok) begin
        // fraction stays below one unit, so the integer part holds
        fc_nxt = fc_inc;
        if (frac_sum > gwp_pkg::WIDE_W'(gwp_pkg::MAXV)) begin
          acc_nxt = gwp_pkg::MAG_MAX;
          int_nxt = gwp_pkg::INT_W'(gwp_pkg::INT_SAT);
        end else begin
          acc_nxt = gwp_pkg::MAG_W'(frac_sum);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      int_r   <= '0;
      fc_r    <= '0;
      point_r <= 1'b0;
      minus_r <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      int_r   <= int_nxt;
      fc_r    <= fc_nxt;
      point_r <= point_nxt;
      minus_r <= minus_nxt;
    end
  end

  // Signed views of the word as it stands.
  always_comb begin
    mag     = gwp_pkg::VALUE_BITS'(acc_r);
    value   = minus_r ? -$signed(mag) : $signed(mag);
    int_cap = (64'(int_r) > gwp_pkg::POWER_MAX) ? gwp_pkg::POWER_MAX : 64'(int_r);
    power   = minus_r ? -$signed(gwp_pkg::POWER_W'(int_cap))
                      : $signed(gwp_pkg::POWER_W'(int_cap));
  end

endmodule

/* rtl/core/gcode_word_parser.sv */
// ----------------------------------------------------------------------------
// gcode_word_parser: byte-stream G-code word parser
// Turns G-code text into one command word per line, with modal G/X/Y/Z/F.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_rx_byte) carries one ASCII byte
//   per transfer. Letters G X Y Z F S (any case) open a field; digits, '-', '.'
//   or ',' build its value; any other byte closes it. A newline or ';' not
//   directly after another terminator issues one command word.
//   Output channel (out_valid / out_stall / out_*) carries the command: the
//   G, X, Y, Z and F values in fixed point x1000 (modal: absent words repeat
//   the last value), and the S integer part flagged by out_power_valid.
//   Throughput: one byte per clock while in_stall is low. The byte lands in
//   an input register; when it is taken from there the parser state updates
//   and, for a terminator, the output register loads and out_valid rises, so
//   the command word is then offered on the output channel.
//   Stall: a pending command holds in the output register while out_stall is high. A terminator
//   that would issue a command then waits in the input register and
//   in_stall rises; other bytes keep flowing since they produce no output.
//   Reset (rst_n low, synchronous): all modal values read zero, no field
//   is open, and both channels go empty.
// ----------------------------------------------------------------------------
module gcode_word_parser (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,

  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_g_word,
  output logic signed [31:0] out_x_pos,
  output logic signed [31:0] out_y_pos,
  output logic signed [31:0] out_z_pos,
  output logic signed [31:0] out_feed_rate,
  output logic               out_power_valid,
  output logic signed [22:0] out_power_level
);

  typedef enum logic [2:0] {
    FLD_NONE, FLD_G, FLD_X, FLD_Y, FLD_Z, FLD_F, FLD_S
  } field_t;

  // ASCII codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_CASE  = 8'h20;
  localparam logic [7:0] CH_LO_G  = 8'h67;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_LO_Y  = 8'h79;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_S  = 8'h73;

  localparam int NMODAL = 5;   // G X Y Z F

  // Input register
  logic [7:0] byte_r;
  logic       byte_vld_r;

  // Parser state
  field_t     field_r, field_nxt;
  logic [5:0] wp_r, wp_nxt;           // words present on this line
  logic       after_term_r, after_term_nxt;
  logic signed [gwp_pkg::VALUE_BITS-1:0] line_r  [NMODAL];
  logic signed [gwp_pkg::POWER_W-1:0]    s_line_r;
  logic signed [gwp_pkg::VALUE_BITS-1:0] modal_r [NMODAL];
  logic signed [gwp_pkg::VALUE_BITS-1:0] modal_nxt [NMODAL];
  logic signed [gwp_pkg::VALUE_BITS-1:0] line_eff [NMODAL];
  logic signed [gwp_pkg::POWER_W-1:0]    s_eff;

  // Output register
  logic                    out_valid_r;
  logic signed [31:0]      out_val_r [NMODAL];
  logic                    out_pvld_r;
  logic signed [22:0]      out_plvl_r;

  // Byte decode
  logic [7:0] lc;
  logic       is_digit, is_minus, is_point, is_term, closing;
  field_t     sel;
  logic       emit, fire, out_free, close_hit;

  gwp_pkg::acc_ctl_t                     acc_ctl;
  logic signed [gwp_pkg::VALUE_BITS-1:0] acc_value;
  logic signed [gwp_pkg::POWER_W-1:0]    acc_power;

  always_comb begin
    lc       = (byte_r >= CH_UP_A && byte_r <= CH_UP_Z) ? byte_r + CH_CASE : byte_r;
    is_digit = byte_r >= CH_ZERO && byte_r <= CH_NINE;
    is_minus = byte_r == CH_MINUS;
    is_point = byte_r == CH_POINT || byte_r == CH_COMMA;
    is_term  = byte_r == CH_NL || byte_r == CH_SEMI;
    closing  = !(is_digit || is_minus || is_point);
    case (lc)
      CH_LO_G: sel = FLD_G;
      CH_LO_X: sel = FLD_X;
      CH_LO_Y: sel = FLD_Y;
      CH_LO_Z: sel = FLD_Z;
      CH_LO_F: sel = FLD_F;
      CH_LO_S: sel = FLD_S;
      default: sel = FLD_NONE;
    endcase

    // Only the first terminator of a run issues a command.
    emit     = is_term && !after_term_r;
    out_free = !out_valid_r || !out_stall;
    fire     = byte_vld_r && (!emit || out_free);
    in_stall = byte_vld_r && !fire;

    acc_ctl.clear = fire && closing;
    acc_ctl.digit = fire && is_digit;
    acc_ctl.minus = fire && is_minus;
    acc_ctl.point = fire && is_point;
    acc_ctl.dval  = 4'(byte_r - CH_ZERO);
  end

  gwp_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (acc_ctl),
    .value (acc_value),
    .power (acc_power)
  );

  // Closing word lands in the line values; an emit on the same byte sees it.
  always_comb begin
    close_hit = fire && closing && field_r != FLD_NONE;
    for (int i = 0; i < NMODAL; i++) begin
      line_eff[i]  = (close_hit && field_r == field_t'(3'(i + 1))) ? acc_value : line_r[i];
      modal_nxt[i] = wp_r[i] ? line_eff[i] : modal_r[i];
    end
    s_eff = (close_hit && field_r == FLD_S) ? acc_power : s_line_r;

    field_nxt      = field_r;
    wp_nxt         = wp_r;
    after_term_nxt = after_term_r;
    if (fire) begin
      if (!is_term) after_term_nxt = 1'b0;
      if (closing) begin
        field_nxt = sel;
        if (sel != FLD_NONE) wp_nxt = wp_r | (6'd1 << (3'(sel) - 3'd1));
      end
      if (emit) begin
        after_term_nxt = 1'b1;
        wp_nxt         = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r   <= 1'b0;
      field_r      <= FLD_NONE;
      wp_r         <= '0;
      after_term_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NMODAL; i++) modal_r[i] <= '0;
    end else begin
      if (!in_stall) byte_vld_r <= in_valid;
      field_r      <= field_nxt;
      wp_r         <= wp_nxt;
      after_term_r <= after_term_nxt;
      if (fire && emit) begin
        out_valid_r <= 1'b1;
        for (int i = 0; i < NMODAL; i++) modal_r[i] <= modal_nxt[i];
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!in_stall) byte_r <= in_rx_byte;
    for (int i = 0; i < NMODAL; i++) line_r[i] <= line_eff[i];
    s_line_r <= s_eff;
    if (fire && emit) begin
      for (int i = 0; i < NMODAL; i++) out_val_r[i] <= 32'(modal_nxt[i]);
      out_pvld_r <= wp_r[5];
      out_plvl_r <= wp_r[5] ? s_eff : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_g_word      = out_val_r[0];
  assign out_x_pos       = out_val_r[1];
  assign out_y_pos       = out_val_r[2];
  assign out_z_pos       = out_val_r[3];
  assign out_feed_rate   = out_val_r[4];
  assign out_power_valid = out_pvld_r;
  assign out_power_level = out_plvl_r;

`ifndef SYNTH
  // A blocked terminator waits in the input register unchanged.
  a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    byte_vld_r && !fire |=> byte_vld_r && $stable(byte_r))
    else $error("blocked byte lost or changed");

  // Issuing a command loads the output and starts a fresh line.
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    fire && emit |=> out_valid_r && wp_r == '0 && after_term_r)
    else $error("command issue did not update output and line state");

  // Never overwrite a pending command.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !(fire && emit))
    else $error("pending command overwritten");
`endif

endmodule

/* dv/tb_gcode_word_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gcode_word_parser: self-checking testbench for the G-code word parser
// Streams G-code text into the parser one byte per transfer and checks every
// command word against a cycle-free model of the parser kept in this file.
// A short table of hand-picked bytes runs first, then random lines with
// random sender idling and receiver stalls in three phases.
// ----------------------------------------------------------------------------
module tb_gcode_word_parser;

  // Character codes the parser treats specially.
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = ";";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_POINT = ".";
  localparam logic [7:0] CH_COMMA = ",";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] WORD_LETTERS [6] = '{"G", "X", "Y", "Z", "F", "S"};

  // Number format: x1000 fixed point, magnitude saturates at 2^31-1.
  localparam int     FRAC_DIGITS = 3;
  localparam longint SCALE       = 1000;
  localparam longint MAG_MAX     = 64'sd2147483647;
  localparam longint POWER_MAX   = 64'sd4194303;

  // Watchdog limit for the whole run, set with plenty of room.
  localparam int CYCLE_LIMIT = 300000;

  // Field selected by the last letter; order matches the result fields.
  typedef enum logic [2:0] {
    FLD_NONE, FLD_G, FLD_X, FLD_Y, FLD_Z, FLD_F, FLD_S
  } field_t;

  typedef struct packed {
    logic signed [31:0] g_word;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic signed [31:0] z_pos;
    logic signed [31:0] feed_rate;
    logic               power_valid;
    logic signed [22:0] power_level;
  } cmd_t;

  // One row of the directed table: the byte, and optionally a hand-written
  // command that its terminator must produce.
  typedef struct {
    logic [7:0] ch;
    bit         typed;
    cmd_t       want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_g_word;
  logic signed [31:0] out_x_pos;
  logic signed [31:0] out_y_pos;
  logic signed [31:0] out_z_pos;
  logic signed [31:0] out_feed_rate;
  logic               out_power_valid;
  logic signed [22:0] out_power_level;

  gcode_word_parser DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_g_word      (out_g_word),
    .out_x_pos       (out_x_pos),
    .out_y_pos       (out_y_pos),
    .out_z_pos       (out_z_pos),
    .out_feed_rate   (out_feed_rate),
    .out_power_valid (out_power_valid),
    .out_power_level (out_power_level)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser model state
  // ---------------------------------------------------------------------------
  field_t cur_field   = FLD_NONE;
  longint acc         = 0;      // magnitude of the value being built
  int     frac_cnt    = 0;      // fraction digits taken so far
  bit     point       = 1'b0;
  bit     neg         = 1'b0;   // sticky: any minus in the value negates it
  longint line_val [6] = '{default: 0};
  bit [5:0] present   = '0;     // letters seen on the current line
  longint modal [5]   = '{default: 0};
  bit     after_term  = 1'b0;

  cmd_t pending_cmds [$];       // commands still owed by the parser

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int n_errors       = 0;
  int n_bytes        = 0;
  int n_cmds         = 0;
  int n_power        = 0;
  int cycle_cnt      = 0;

  // Advance the model by one byte. Returns 1 when the byte ends a line and a
  // command is issued, with that command in cmd.
  function automatic bit parse_byte(input logic [7:0] c, output cmd_t cmd);
    logic [7:0] lc;
    field_t     sel;
    bit         term;
    longint     m;
    longint     p;
    cmd = '0;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    term = (c == CH_NL || c == CH_SEMI);
    if (!term) after_term = 1'b0;

    if (c >= "0" && c <= "9") begin
      m = longint'(c - CH_ZERO);
      if (!point) begin
        m = m * SCALE;
        if (m > MAG_MAX || acc > (MAG_MAX - m) / 10) acc = MAG_MAX;
        else acc = acc * 10 + m;
      end else if (frac_cnt < FRAC_DIGITS) begin
        // digit weight: 100, 10, 1 for the first three decimals
        frac_cnt++;
        repeat (FRAC_DIGITS - frac_cnt) m = m * 10;
        if (m > MAG_MAX - acc) acc = MAG_MAX;
        else acc = acc + m;
      end
      return 1'b0;
    end
    if (c == CH_MINUS) begin
      neg = 1'b1;
      return 1'b0;
    end
    if (c == CH_POINT || c == CH_COMMA) begin
      point = 1'b1;
      return 1'b0;
    end

    // Anything else closes the open value; digits with no letter are dropped.
    if (cur_field != FLD_NONE) line_val[int'(cur_field) - 1] = neg ? -acc : acc;
    cur_field = FLD_NONE;
    acc = 0;
    frac_cnt = 0;
    point = 1'b0;
    neg = 1'b0;

    case (lc)
      "g":     sel = FLD_G;
      "x":     sel = FLD_X;
      "y":     sel = FLD_Y;
      "z":     sel = FLD_Z;
      "f":     sel = FLD_F;
      "s":     sel = FLD_S;
      default: sel = FLD_NONE;
    endcase
    if (sel != FLD_NONE) begin
      // a repeated letter just reopens the field and overwrites it later
      cur_field = sel;
      present[int'(sel) - 1] = 1'b1;
      return 1'b0;
    end
    if (!term || after_term) return 1'b0;
    after_term = 1'b1;

    // G/X/Y/Z/F are modal: update only the ones present on this line.
    for (int i = 0; i < 5; i++)
      if (present[i]) modal[i] = line_val[i];
    cmd.g_word    = modal[0][31:0];
    cmd.x_pos     = modal[1][31:0];
    cmd.y_pos     = modal[2][31:0];
    cmd.z_pos     = modal[3][31:0];
    cmd.feed_rate = modal[4][31:0];
    if (present[5]) begin
      p = line_val[5] / SCALE;   // truncates toward zero
      if (p > POWER_MAX) p = POWER_MAX;
      if (p < -POWER_MAX) p = -POWER_MAX;
      cmd.power_valid = 1'b1;
      cmd.power_level = p[22:0];
    end
    line_val = '{default: 0};
    present = '0;
    return 1'b1;
  endfunction

  // Drive one byte and hold it until accepted. Called right after a falling
  // edge, returns right after a falling edge. A typed row overrides the
  // model's command with the hand-written one.
  task automatic send_byte(input logic [7:0] b, input bit typed, input cmd_t typed_cmd);
    cmd_t pred;
    bit   emit;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_bytes++;
    emit = parse_byte(b, pred);
    if (typed) pending_cmds.push_back(typed_cmd);
    else if (emit) pending_cmds.push_back(pred);
    @(negedge clk);
  endtask

  task automatic cmp_field(input string name, input logic signed [63:0] want,
                           input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  //   empty line right after reset, a repeated terminator, byte extremes,
  //   lowercase letters, minus before the point, a second point (comma),
  //   a repeated letter (correction), a digit with no letter open, and an
  //   S value that saturates negative.
  // ---------------------------------------------------------------------------
  dir_row_t dir_tab [26] = '{
    '{CH_NL,    1'b1, '0},     // empty line after reset: all zero, no S
    '{CH_SEMI,  1'b0, '0},     // second terminator issues nothing
    '{8'h00,    1'b0, '0},
    '{8'hFF,    1'b0, '0},
    '{"g",      1'b0, '0},
    '{"1",      1'b0, '0},
    '{"x",      1'b0, '0},
    '{CH_MINUS, 1'b0, '0},
    '{CH_POINT, 1'b0, '0},
    '{"5",      1'b0, '0},
    '{CH_COMMA, 1'b0, '0},     // second point is ignored
    '{"7",      1'b0, '0},
    '{"X",      1'b0, '0},     // correction: X restarts
    '{"3",      1'b0, '0},
    '{CH_SPACE, 1'b0, '0},
    '{"4",      1'b0, '0},     // no letter open: discarded
    '{"S",      1'b0, '0},
    '{CH_MINUS, 1'b0, '0},
    '{"9",      1'b0, '0},
    '{"9",      1'b0, '0},
    '{"9",      1'b0, '0},
    '{"9",      1'b0, '0},
    '{"9",      1'b0, '0},
    '{"9",      1'b0, '0},
    '{"9",      1'b0, '0},     // magnitude saturates here
    '{CH_NL,    1'b1, '{g_word: 1000, x_pos: 3000, y_pos: 0, z_pos: 0,
                        feed_rate: 0, power_valid: 1'b1, power_level: -2147483}}
  };

  // ---------------------------------------------------------------------------
  // Receiver: random stall, changed on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // Check every accepted command word against the oldest expectation.
  always @(posedge clk) begin : result_check
    cmd_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_cmds.size() == 0) begin
        $error("command word with nothing expected: g=%0d x=%0d y=%0d",
               out_g_word, out_x_pos, out_y_pos);
        n_errors++;
      end else begin
        want = pending_cmds.pop_front();
        n_cmds++;
        if (want.power_valid) n_power++;
        cmp_field("g_word",      want.g_word,      out_g_word);
        cmp_field("x_pos",       want.x_pos,       out_x_pos);
        cmp_field("y_pos",       want.y_pos,       out_y_pos);
        cmp_field("z_pos",       want.z_pos,       out_z_pos);
        cmp_field("feed_rate",   want.feed_rate,   out_feed_rate);
        cmp_field("power_valid", want.power_valid, out_power_valid);
        cmp_field("power_level", want.power_level, out_power_level);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0] line_q [$];
    logic [7:0] letter;
    int         target;
    send_idle_pct  = 32;
    recv_stall_pct = 72;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_byte(dir_tab[i].ch, dir_tab[i].typed, dir_tab[i].want);

    // Three idling phases: sender-light/receiver-heavy, the reverse, none.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 32 : (ph == 1) ? 72 : 0;
      recv_stall_pct = (ph == 0) ? 72 : (ph == 1) ? 32 : 0;
      target = n_bytes + 284;
      while (n_bytes < target) begin
        line_q.delete();
        if ($urandom_range(99) < 85) begin
          // Well-formed line: a few letter/value tokens and a terminator.
          repeat ($urandom_range(5)) begin
            if ($urandom_range(1)) line_q.push_back(CH_SPACE);
            letter = WORD_LETTERS[$urandom_range(5)];
            if ($urandom_range(1)) letter = letter + 8'd32;
            line_q.push_back(letter);
            if ($urandom_range(99) < 30) line_q.push_back(CH_MINUS);
            // mostly short integers, now and then long enough to saturate
            repeat (($urandom_range(9) == 0) ? $urandom_range(11, 6) : $urandom_range(3))
              line_q.push_back(8'(CH_ZERO + $urandom_range(9)));
            if ($urandom_range(99) < 8) line_q.push_back(CH_MINUS);
            if ($urandom_range(1)) begin
              line_q.push_back(($urandom_range(3) == 0) ? CH_COMMA : CH_POINT);
              repeat ($urandom_range(5)) line_q.push_back(8'(CH_ZERO + $urandom_range(9)));
              if ($urandom_range(19) == 0) begin
                line_q.push_back(CH_POINT);
                line_q.push_back(8'(CH_ZERO + $urandom_range(9)));
              end
            end
          end
          line_q.push_back($urandom_range(1) ? CH_NL : CH_SEMI);
          if ($urandom_range(6) == 0) line_q.push_back($urandom_range(1) ? CH_NL : CH_SEMI);
        end else begin
          // Noise: any byte value, breaks tokens and lines at random.
          repeat ($urandom_range(6, 1)) line_q.push_back(8'($urandom_range(255)));
        end
        foreach (line_q[k]) send_byte(line_q[k], 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    // Drain, then give the two-stage pipe time to show any stray word.
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Streamed %0d bytes of G-code text in %0d cycles.", n_bytes, cycle_cnt);
    $display("Checked %0d command words, %0d of them carrying S.", n_cmds, n_power);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* gcode_word_parser.f */
rtl/core/gwp_pkg.sv
rtl/core/gwp_accum.sv
rtl/core/gcode_word_parser.sv
dv/tb_gcode_word_parser.sv
